@@ rtl/core/hvd_pkg.sv @@
// hvd_pkg: constants, widths and the arctangent table shared by the haversine pipeline
// used by hvd_sincos, hvd_isqrt and haversine_distance; no dependencies
package hvd_pkg;

  localparam int ANGLE_FRAC_BITS = 20;
  localparam int DIST_FRAC_BITS  = 8;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int DIST_W = 23;

  // magnitude of a coordinate difference, or twice a latitude
  localparam int MAG_W = LON_W + 1;

  // binary angle: full turn is 2^ANG_W
  localparam int ANG_W      = 32;
  localparam int TURN_SHIFT = 31 - ANGLE_FRAC_BITS;

  // mag / 45 by reciprocal
  localparam int QA_K  = MAG_W + 6;
  localparam int QA_MW = MAG_W + 1;
  localparam int QA_W  = MAG_W - 5;
  localparam int PA_W  = MAG_W + QA_MW;
  localparam longint unsigned QA_M = ((64'd1 << QA_K) + 64'd44) / 64'd45;

  // (rem << shift) + 180, then / 360 by reciprocal
  localparam int RT_W  = TURN_SHIFT + 7;
  localparam int RD_W  = RT_W - 3;
  localparam int RD_K  = RD_W + 6;
  localparam int RD_MW = RD_W + 1;
  localparam int PC_W  = RD_W + RD_MW;
  localparam int Q2_W  = RD_W - 5;
  localparam longint unsigned RD_M = ((64'd1 << RD_K) + 64'd44) / 64'd45;
  localparam int HALF_DEG_TURN = 180;

  localparam int CORDIC_STEPS = 30;
  localparam int CS_W         = 33;
  localparam int TRIG_W       = 32;
  localparam longint CORDIC_INV_GAIN = 652032874;
  localparam longint ONE_Q30 = 64'd1 << 30;

  // square root: radicand is a Q30 value in [0, 1], shifted up by 30
  localparam int ROOT_W = 31;
  localparam int REM_W  = 34;

  // km per full binary turn of the half central angle, Q16
  localparam longint unsigned DIST_SCALE = 64'd5246834913;
  localparam int DIST_SHIFT = 48 - DIST_FRAC_BITS;
  localparam longint unsigned DIST_ROUND = 64'd1 << (47 - DIST_FRAC_BITS);
  localparam longint unsigned DIST_MAX   = (64'd1 << DIST_W) - 64'd1;

  localparam int SC_LAT    = 3 + 1 + CORDIC_STEPS + 1;
  localparam int SQ_LAT    = ROOT_W;
  localparam int TOTAL_LAT = 1 + SC_LAT + 3 + SQ_LAT + CORDIC_STEPS + 3;

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turn(input int i);
    logic [ANG_W-1:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/hvd_sincos.sv @@
// hvd_sincos: degree magnitude to binary angle, quadrant fold and pipelined rotation cordic
// depends on hvd_pkg; advances when en is high
module hvd_sincos (
  input  logic                                clk,
  input  logic                                en,
  input  logic        [hvd_pkg::MAG_W-1:0]    mag,
  output logic signed [hvd_pkg::TRIG_W-1:0]   sin_q30,
  output logic signed [hvd_pkg::TRIG_W-1:0]   cos_q30
);

  logic [hvd_pkg::PA_W-1:0]  prod_a;
  logic [hvd_pkg::QA_W-1:0]  qa;
  logic [hvd_pkg::MAG_W-1:0] mag_a;

  logic [hvd_pkg::MAG_W-1:0] rem_full;
  logic [hvd_pkg::RT_W-1:0]  t_next;
  logic [hvd_pkg::RT_W-1:0]  t;
  logic [hvd_pkg::QA_W-1:0]  qb;

  logic [hvd_pkg::PC_W-1:0]  prod_c;
  logic [63:0]               ang_sum;
  logic [hvd_pkg::ANG_W-1:0] ang;

  logic                      flip_next;
  logic [hvd_pkg::ANG_W-1:0] fold_next;

  logic signed [hvd_pkg::CS_W-1:0] cx [0:hvd_pkg::CORDIC_STEPS];
  logic signed [hvd_pkg::CS_W-1:0] cy [0:hvd_pkg::CORDIC_STEPS];
  logic signed [hvd_pkg::CS_W-1:0] cz [0:hvd_pkg::CORDIC_STEPS];
  logic                            fl [0:hvd_pkg::CORDIC_STEPS];

  // mag / 45
  assign prod_a = hvd_pkg::PA_W'(mag) * hvd_pkg::PA_W'(hvd_pkg::QA_M);

  always_ff @(posedge clk) begin
    if (en) begin
      qa    <= prod_a[hvd_pkg::QA_K +: hvd_pkg::QA_W];
      mag_a <= mag;
    end
  end

  // remainder below 45, then the rounding offset of half a degree step
  assign rem_full = mag_a - hvd_pkg::MAG_W'(qa) * hvd_pkg::MAG_W'(45);
  assign t_next   = (hvd_pkg::RT_W'(rem_full[5:0]) << hvd_pkg::TURN_SHIFT)
                    + hvd_pkg::RT_W'(hvd_pkg::HALF_DEG_TURN);

  always_ff @(posedge clk) begin
    if (en) begin
      t  <= t_next;
      qb <= qa;
    end
  end

  assign prod_c  = hvd_pkg::PC_W'(t[hvd_pkg::RT_W-1:3]) * hvd_pkg::PC_W'(hvd_pkg::RD_M);
  assign ang_sum = (64'(qb) << (hvd_pkg::TURN_SHIFT - 3))
                   + 64'(prod_c[hvd_pkg::RD_K +: hvd_pkg::Q2_W]);

  always_ff @(posedge clk) begin
    if (en) begin
      ang <= ang_sum[hvd_pkg::ANG_W-1:0];
    end
  end

  // fold second and third quadrant by half a turn
  assign flip_next = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign fold_next = flip_next ? {~ang[31], ang[30:0]} : ang;

  always_ff @(posedge clk) begin
    if (en) begin
      cz[0] <= hvd_pkg::CS_W'($signed(fold_next));
      fl[0] <= flip_next;
    end
  end

  assign cx[0] = hvd_pkg::CS_W'(hvd_pkg::CORDIC_INV_GAIN);
  assign cy[0] = '0;

  for (genvar i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - hvd_pkg::CS_W'(hvd_pkg::atan_turn(i));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + hvd_pkg::CS_W'(hvd_pkg::atan_turn(i));
        end
        fl[i+1] <= fl[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q30 <= hvd_pkg::TRIG_W'(fl[hvd_pkg::CORDIC_STEPS] ? -cy[hvd_pkg::CORDIC_STEPS]
                                                            : cy[hvd_pkg::CORDIC_STEPS]);
      cos_q30 <= hvd_pkg::TRIG_W'(fl[hvd_pkg::CORDIC_STEPS] ? -cx[hvd_pkg::CORDIC_STEPS]
                                                            : cx[hvd_pkg::CORDIC_STEPS]);
    end
  end

endmodule

@@ rtl/core/hvd_isqrt.sv @@
// hvd_isqrt: pipelined digit-by-digit floor square root of a q30 value shifted up by 30
// depends on hvd_pkg; one result bit per stage, advances when en is high
module hvd_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hvd_pkg::ROOT_W-1:0]    radicand,
  output logic [hvd_pkg::ROOT_W-1:0]    root
);

  logic [hvd_pkg::ROOT_W-1:0] src [0:hvd_pkg::ROOT_W];
  logic [hvd_pkg::ROOT_W-1:0] res [0:hvd_pkg::ROOT_W];
  logic [hvd_pkg::REM_W-1:0]  rem [0:hvd_pkg::ROOT_W];

  assign src[0] = radicand;
  assign res[0] = '0;
  assign rem[0] = '0;

  for (genvar k = 0; k < hvd_pkg::ROOT_W; k++) begin : g_digit
    logic [2*hvd_pkg::ROOT_W-1:0] word;
    logic [hvd_pkg::REM_W+1:0]    acc;
    logic [hvd_pkg::REM_W+1:0]    trial;

    // radicand sits below one leading zero bit of a 62-bit word, lower 30 bits zero
    assign word  = {1'b0, src[k], 30'b0};
    assign acc   = {rem[k], word[2*hvd_pkg::ROOT_W-1-2*k -: 2]};
    assign trial = (hvd_pkg::REM_W+2)'({res[k], 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        src[k+1] <= src[k];
        if (acc >= trial) begin
          rem[k+1] <= hvd_pkg::REM_W'(acc - trial);
          res[k+1] <= {res[k][hvd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= hvd_pkg::REM_W'(acc);
          res[k+1] <= {res[k][hvd_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = res[hvd_pkg::ROOT_W];

endmodule

@@ rtl/core/haversine_distance.sv @@
// haversine_distance: great-circle distance of two points, fully pipelined fixed point
// depends on hvd_pkg, hvd_sincos and hvd_isqrt
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------
//   in      | in_valid / in_stall | lat_a, lon_a, lat_b, lon_b (deg Q20)
//   out     | out_valid/out_stall | distance_km (km Q8)
//
// one item per cycle unless the output stalls; pipeline depth is set by the two
// 30-step cordic chains and the 31-stage square root
// rst clears only the valid bits; payload registers are not reset
// a stall on the output with a result waiting freezes the whole pipeline and
// raises in_stall; bubbles move on as long as the output register is free
module haversine_distance (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [hvd_pkg::LAT_W-1:0]   lat_a,
  input  logic signed [hvd_pkg::LON_W-1:0]   lon_a,
  input  logic signed [hvd_pkg::LAT_W-1:0]   lat_b,
  input  logic signed [hvd_pkg::LON_W-1:0]   lon_b,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [hvd_pkg::DIST_W-1:0]  distance_km
);

  logic                             adv;
  logic [hvd_pkg::TOTAL_LAT-1:0]    vld;

  logic signed [hvd_pkg::MAG_W-1:0] dlat, dlon, la2, lb2;
  logic [hvd_pkg::MAG_W-1:0]        dlat_mag, dlon_mag, la_mag, lb_mag;

  logic signed [hvd_pkg::TRIG_W-1:0] u, v, c1, c2;
  logic signed [63:0]                pu, pv, pc;
  logic signed [32:0]                u2, v2, cc, u2p;
  logic signed [65:0]                pcv;
  logic signed [33:0]                cv;
  logic signed [34:0]                hav;
  logic [hvd_pkg::ROOT_W-1:0]        a_next, a_cl, na_cl;
  logic [hvd_pkg::ROOT_W-1:0]        s_root, c_root;

  logic signed [hvd_pkg::CS_W-1:0] vx [0:hvd_pkg::CORDIC_STEPS];
  logic signed [hvd_pkg::CS_W-1:0] vy [0:hvd_pkg::CORDIC_STEPS];
  logic signed [hvd_pkg::CS_W-1:0] vz [0:hvd_pkg::CORDIC_STEPS];

  logic [hvd_pkg::ROOT_W-1:0] zc;
  logic [47:0]                p_lo;
  logic [48:0]                p_hi;
  logic [64:0]                dsum;
  logic [64:0]                dsh;

  assign in_stall = out_valid & out_stall;
  assign adv      = ~in_stall;
  assign out_valid = vld[hvd_pkg::TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[hvd_pkg::TOTAL_LAT-2:0], in_valid};
    end
  end

  // input stage: difference magnitudes, latitudes doubled for the full-turn scale
  assign dlat = hvd_pkg::MAG_W'(lat_b) - hvd_pkg::MAG_W'(lat_a);
  assign dlon = hvd_pkg::MAG_W'(lon_b) - hvd_pkg::MAG_W'(lon_a);
  assign la2  = hvd_pkg::MAG_W'(lat_a) <<< 1;
  assign lb2  = hvd_pkg::MAG_W'(lat_b) <<< 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      dlat_mag <= dlat[hvd_pkg::MAG_W-1] ? -dlat : dlat;
      dlon_mag <= dlon[hvd_pkg::MAG_W-1] ? -dlon : dlon;
      la_mag   <= la2[hvd_pkg::MAG_W-1] ? -la2 : la2;
      lb_mag   <= lb2[hvd_pkg::MAG_W-1] ? -lb2 : lb2;
    end
  end

  hvd_sincos u_sc_dlat (.clk(clk), .en(adv), .mag(dlat_mag), .sin_q30(u),  .cos_q30());
  hvd_sincos u_sc_dlon (.clk(clk), .en(adv), .mag(dlon_mag), .sin_q30(v),  .cos_q30());
  hvd_sincos u_sc_lata (.clk(clk), .en(adv), .mag(la_mag),   .sin_q30(),   .cos_q30(c1));
  hvd_sincos u_sc_latb (.clk(clk), .en(adv), .mag(lb_mag),   .sin_q30(),   .cos_q30(c2));

  // haversine term
  assign pu = 64'(u) * 64'(u);
  assign pv = 64'(v) * 64'(v);
  assign pc = 64'(c1) * 64'(c2);

  always_ff @(posedge clk) begin
    if (adv) begin
      u2 <= pu[62:30];
      v2 <= pv[62:30];
      cc <= pc[62:30];
    end
  end

  assign pcv = 66'(cc) * 66'(v2);

  always_ff @(posedge clk) begin
    if (adv) begin
      cv  <= pcv[63:30];
      u2p <= u2;
    end
  end

  assign hav = 35'(u2p) + 35'(cv);

  // saturate to [0, 1] in q30
  always_comb begin
    if (hav < 0) begin
      a_next = '0;
    end else if (hav > 35'(hvd_pkg::ONE_Q30)) begin
      a_next = hvd_pkg::ROOT_W'(hvd_pkg::ONE_Q30);
    end else begin
      a_next = hav[hvd_pkg::ROOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cl  <= a_next;
      na_cl <= hvd_pkg::ROOT_W'(hvd_pkg::ONE_Q30) - a_next;
    end
  end

  hvd_isqrt u_sq_s (.clk(clk), .en(adv), .radicand(a_cl),  .root(s_root));
  hvd_isqrt u_sq_c (.clk(clk), .en(adv), .radicand(na_cl), .root(c_root));

  // vectoring cordic: atan2(s, c)
  assign vx[0] = hvd_pkg::CS_W'(c_root);
  assign vy[0] = hvd_pkg::CS_W'(s_root);
  assign vz[0] = '0;

  for (genvar i = 0; i < hvd_pkg::CORDIC_STEPS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + hvd_pkg::CS_W'(hvd_pkg::atan_turn(i));
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - hvd_pkg::CS_W'(hvd_pkg::atan_turn(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vz[hvd_pkg::CORDIC_STEPS] < 0) begin
        zc <= '0;
      end else if (vz[hvd_pkg::CORDIC_STEPS] > hvd_pkg::CS_W'(hvd_pkg::ONE_Q30)) begin
        zc <= hvd_pkg::ROOT_W'(hvd_pkg::ONE_Q30);
      end else begin
        zc <= vz[hvd_pkg::CORDIC_STEPS][hvd_pkg::ROOT_W-1:0];
      end
    end
  end

  // distance scale split into two partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo <= 48'(zc) * 48'(hvd_pkg::DIST_SCALE[15:0]);
      p_hi <= 49'(zc) * 49'(hvd_pkg::DIST_SCALE[32:16]);
    end
  end

  assign dsum = (65'(p_hi) << 16) + 65'(p_lo) + 65'(hvd_pkg::DIST_ROUND);
  assign dsh  = dsum >> hvd_pkg::DIST_SHIFT;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dsh > 65'(hvd_pkg::DIST_MAX)) begin
        distance_km <= hvd_pkg::DIST_W'(hvd_pkg::DIST_MAX);
      end else begin
        distance_km <= dsh[hvd_pkg::DIST_W-1:0];
      end
    end
  end

endmodule
